// ----- sv/i2cm_pkg.sv -----
// shared types and constants for the i2c eeprom transaction master
// request, response and configuration structs, phase encoding, register codes
// no dependencies
`default_nettype none

package i2cm_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_SELECT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_WAIT_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS      = 2'd2;

   localparam logic [6:0]  DEVICE_SELECT_RESET  = 7'd80;
   localparam logic [15:0] ACK_WAIT_LIMIT_RESET = 16'd60000;
   localparam logic [15:0] GAP_TICKS_RESET      = 16'd4400;

   localparam logic [2:0] HDR_CTRL   = 3'd0;
   localparam logic [2:0] HDR_ADDR   = 3'd1;
   localparam logic [2:0] HDR_RSTART = 3'd2;
   localparam logic [2:0] HDR_RCTRL  = 3'd3;
   localparam logic [2:0] HDR_DATA   = 3'd4;

   localparam logic [3:0] BIT_LAST = 4'd15;

   typedef enum logic [10:0] {
      PH_IDLE     = 11'b000_0000_0001,
      PH_GAP      = 11'b000_0000_0010,
      PH_START    = 11'b000_0000_0100,
      PH_WBITS    = 11'b000_0000_1000,
      PH_WTAIL    = 11'b000_0001_0000,
      PH_ACK_LOW  = 11'b000_0010_0000,
      PH_ACK_POLL = 11'b000_0100_0000,
      PH_ACK_END  = 11'b000_1000_0000,
      PH_RBITS    = 11'b001_0000_0000,
      PH_MACK     = 11'b010_0000_0000,
      PH_STOP     = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic       command_start;
      logic [1:0] op;
      logic [7:0] word_address;
      logic [7:0] byte_count;
      logic [7:0] data_byte;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       byte_taken;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       ack_missing;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  device_select;
      logic [15:0] ack_wait_limit;
      logic [15:0] gap_ticks;
   } cfg_type;

endpackage

`default_nettype wire

// ----- sv/i2cm_csr.sv -----
// configuration registers of the i2c eeprom transaction master
// depends on i2cm_pkg for the register codes and the cfg struct
`default_nettype none

module i2cm_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [i2cm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [i2cm_pkg::CSR_DATA_W-1:0]     csr_data,
   output i2cm_pkg::cfg_type                   cfg
);
   import i2cm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEVICE_SELECT:  cfg_in.device_select  = csr_data[6:0];
            CSR_ACK_WAIT_LIMIT: cfg_in.ack_wait_limit = csr_data;
            CSR_GAP_TICKS:      cfg_in.gap_ticks      = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_select  <= DEVICE_SELECT_RESET;
         cfg_ff.ack_wait_limit <= ACK_WAIT_LIMIT_RESET;
         cfg_ff.gap_ticks      <= GAP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/i2cm_engine.sv -----
// bus phase sequencer: one tick request in, one line-drive response out
// holds the transaction state; depends on i2cm_pkg
`default_nettype none

module i2cm_engine (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     step,
   input  wire i2cm_pkg::req_type  tick,
   input  wire i2cm_pkg::cfg_type  cfg,
   output i2cm_pkg::rsp_type       result
);
   import i2cm_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0]  bit_counter_ff, bit_counter_in;
   logic [7:0]  shift_reg_ff, shift_reg_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] wait_counter_ff, wait_counter_in;
   logic [1:0]  latched_op_ff, latched_op_in;
   logic [7:0]  latched_address_ff, latched_address_in;
   logic [2:0]  header_step_ff, header_step_in;
   logic        ackbit;
   logic [7:0]  rx_shift;

   always_comb begin
      phase_in           = phase_ff;
      bit_counter_in     = bit_counter_ff;
      shift_reg_in       = shift_reg_ff;
      bytes_left_in      = bytes_left_ff;
      wait_counter_in    = wait_counter_ff;
      latched_op_in      = latched_op_ff;
      latched_address_in = latched_address_ff;
      header_step_in     = header_step_ff;
      ackbit             = (bytes_left_ff == 8'd0);
      rx_shift           = {shift_reg_ff[6:0], tick.sda_sample};

      result             = '0;
      result.scl_level   = 1'b1;
      result.sda_level   = 1'b1;
      result.busy_res    = 1'b1;

      unique case (phase_ff)
         PH_IDLE: begin
            result.busy_res = 1'b0;
            if (tick.command_start) begin
               result.busy_res    = 1'b1;
               latched_op_in      = tick.op;
               latched_address_in = tick.word_address;
               bytes_left_in      = tick.op[1] ? tick.byte_count : 8'd1;
               header_step_in     = HDR_CTRL;
               wait_counter_in    = cfg.gap_ticks;
               phase_in           = PH_GAP;
            end
         end
         PH_GAP: begin
            if (wait_counter_ff == 16'd0) begin
               phase_in       = PH_START;
               bit_counter_in = 4'd0;
            end else begin
               wait_counter_in = wait_counter_ff - 16'd1;
            end
         end
         PH_START: begin
            priority if (bit_counter_ff == 4'd0) begin
               bit_counter_in = 4'd1;
            end else if (bit_counter_ff == 4'd1) begin
               result.sda_level = 1'b0;
               bit_counter_in   = 4'd2;
            end else begin
               result.scl_level = 1'b0;
               result.sda_level = 1'b0;
               if (header_step_ff == HDR_CTRL) begin
                  shift_reg_in = {cfg.device_select, 1'b0};
               end else begin
                  shift_reg_in   = {cfg.device_select, 1'b1};
                  header_step_in = HDR_RCTRL;
               end
               bit_counter_in = 4'd0;
               phase_in       = PH_WBITS;
            end
         end
         PH_WBITS: begin
            result.sda_level = shift_reg_ff[7];
            result.scl_level = bit_counter_ff[0];
            if (bit_counter_ff == BIT_LAST) begin
               phase_in = PH_WTAIL;
            end else begin
               if (bit_counter_ff[0]) shift_reg_in = {shift_reg_ff[6:0], 1'b0};
               bit_counter_in = bit_counter_ff + 4'd1;
            end
         end
         PH_WTAIL: begin
            result.scl_level = 1'b0;
            result.sda_level = shift_reg_ff[7];
            phase_in         = PH_ACK_LOW;
         end
         PH_ACK_LOW: begin
            result.scl_level = 1'b0;
            wait_counter_in  = 16'd0;
            phase_in         = PH_ACK_POLL;
         end
         PH_ACK_POLL: begin
            priority if (!tick.sda_sample) begin
               phase_in = PH_ACK_END;
            end else if (wait_counter_ff >= cfg.ack_wait_limit) begin
               result.ack_missing = 1'b1;
               phase_in           = PH_ACK_END;
            end else begin
               wait_counter_in = wait_counter_ff + 16'd1;
            end
         end
         PH_ACK_END: begin
            result.scl_level = 1'b0;
            phase_in         = PH_STOP;
            bit_counter_in   = 4'd0;
            priority if (header_step_ff == HDR_CTRL) begin
               shift_reg_in   = latched_address_ff;
               header_step_in = HDR_ADDR;
               phase_in       = PH_WBITS;
            end else if (header_step_ff == HDR_ADDR && latched_op_ff[0]) begin
               header_step_in = HDR_RSTART;
               phase_in       = PH_START;
            end else if (header_step_ff == HDR_RCTRL) begin
               if (bytes_left_ff != 8'd0) begin
                  shift_reg_in = 8'd0;
                  phase_in     = PH_RBITS;
               end
            end else if (header_step_ff == HDR_ADDR || header_step_ff == HDR_DATA) begin
               if (bytes_left_ff != 8'd0) begin
                  shift_reg_in      = tick.data_byte;
                  result.byte_taken = 1'b1;
                  bytes_left_in     = bytes_left_ff - 8'd1;
                  header_step_in    = HDR_DATA;
                  phase_in          = PH_WBITS;
               end
            end else begin
               phase_in = PH_STOP;
            end
         end
         PH_RBITS: begin
            result.scl_level = bit_counter_ff[0];
            if (bit_counter_ff[0]) shift_reg_in = rx_shift;
            if (bit_counter_ff == BIT_LAST) begin
               result.read_data  = rx_shift;
               result.read_valid = 1'b1;
               result.read_last  = (bytes_left_ff <= 8'd1);
               if (bytes_left_ff != 8'd0) bytes_left_in = bytes_left_ff - 8'd1;
               bit_counter_in = 4'd0;
               phase_in       = PH_MACK;
            end else begin
               bit_counter_in = bit_counter_ff + 4'd1;
            end
         end
         PH_MACK: begin
            priority if (bit_counter_ff == 4'd0) begin
               result.scl_level = 1'b0;
               bit_counter_in   = 4'd1;
            end else if (bit_counter_ff == 4'd1) begin
               result.scl_level = 1'b0;
               result.sda_level = ackbit;
               bit_counter_in   = 4'd2;
            end else if (bit_counter_ff == 4'd2) begin
               result.sda_level = ackbit;
               bit_counter_in   = 4'd3;
            end else begin
               result.scl_level = 1'b0;
               result.sda_level = ackbit;
               bit_counter_in   = 4'd0;
               phase_in         = ackbit ? PH_STOP : PH_RBITS;
            end
         end
         PH_STOP: begin
            priority if (bit_counter_ff == 4'd0) begin
               result.scl_level = 1'b0;
               bit_counter_in   = 4'd1;
            end else if (bit_counter_ff == 4'd1) begin
               result.scl_level = 1'b0;
               result.sda_level = 1'b0;
               bit_counter_in   = 4'd2;
            end else if (bit_counter_ff == 4'd2) begin
               result.sda_level = 1'b0;
               bit_counter_in   = 4'd3;
            end else begin
               bit_counter_in = 4'd0;
               phase_in       = PH_IDLE;
            end
         end
         default: begin
            result.busy_res = 1'b0;
            phase_in        = PH_IDLE;
            bit_counter_in  = 4'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         bit_counter_ff     <= '0;
         shift_reg_ff       <= '0;
         bytes_left_ff      <= '0;
         wait_counter_ff    <= '0;
         latched_op_ff      <= '0;
         latched_address_ff <= '0;
         header_step_ff     <= HDR_CTRL;
      end else if (step) begin
         phase_ff           <= phase_in;
         bit_counter_ff     <= bit_counter_in;
         shift_reg_ff       <= shift_reg_in;
         bytes_left_ff      <= bytes_left_in;
         wait_counter_ff    <= wait_counter_in;
         latched_op_ff      <= latched_op_in;
         latched_address_ff <= latched_address_in;
         header_step_ff     <= header_step_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/i2c_eeprom_transaction_master_unit.sv -----
// top level of the i2c eeprom transaction master
// input register, phase sequencer, response register and configuration registers
// depends on i2cm_pkg, i2cm_csr, i2cm_engine
//
// Each request is one bus tick: the command fields, the next write byte and the
// sampled SDA level. Each request yields exactly one response with the SCL/SDA
// drive levels and the busy, byte_taken, read and ack_missing flags of that tick.
// A request is taken at a clock edge where req_valid is high and req_stall low;
// a response is taken where rsp_valid is high and rsp_stall low.
// A request passes through the input register, then through the sequencer into the
// response register. Throughput is one request per clock while rsp_stall does not hold
// the response, set by the single sequencer step between those registers.
// When rsp_stall holds the response, one more request waits in the input register;
// only then does req_stall rise, and it follows rsp_stall in the same cycle.
// The csr port is always ready and writes device_select, ack_wait_limit and
// gap_ticks by index; write it only while no transaction is running.
// Synchronous reset empties both registers, returns the sequencer to idle and
// loads the register defaults (device 80, ack limit 60000, gap 4400).
`default_nettype none

module i2c_eeprom_transaction_master_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire i2cm_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output i2cm_pkg::rsp_type                   rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [i2cm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [i2cm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import i2cm_pkg::*;

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type step_result;
   logic    advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .tick   (in_data_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_data_ff <= req_data;
      if (advance) out_data_ff <= step_result;
   end

   // stall only when both registers are full and the output is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall && in_valid_ff))
      else $error("request stalled without a held response");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.read_valid || rsp_data.byte_taken)) |-> rsp_data.busy_res)
      else $error("data event outside a transaction");

   a_last_with_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.read_last) |-> rsp_data.read_valid)
      else $error("read_last without read_valid");

   a_missing_scl_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ack_missing) |-> (rsp_data.scl_level && !rsp_data.byte_taken))
      else $error("ack timeout outside a poll tick");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ----- test/i2cm_line_monitor.sv -----
// bus line monitor for the i2c eeprom transaction master testbench
// predicts the response of every accepted request tick and compares it
// depends on i2cm_pkg
module i2cm_line_monitor
   import i2cm_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_stall,
   input  req_type                 req_data,
   input  wire                     rsp_valid,
   input  wire                     rsp_stall,
   input  rsp_type                 rsp_data,
   input  wire                     csr_valid,
   input  wire                     csr_ready,
   input  wire  [CSR_INDEX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_data,
   output int                      errors,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type    cfg;
   phase_type  phase;
   logic [3:0] bit_count;
   logic [7:0] shifter;
   logic [7:0] bytes_to_go;
   logic [15:0] tick_count;
   logic [1:0] cur_op;
   logic [7:0] cur_address;
   logic [2:0] hdr;
   rsp_type    expected_lines[$];
   int         mismatches = 0;

   function automatic rsp_type next_bus_tick(input req_type r);
      rsp_type o;
      logic    ack_level;
      o = '0;
      o.scl_level = 1'b1;
      o.sda_level = 1'b1;
      o.busy_res  = 1'b1;
      case (phase)
         PH_IDLE: begin
            o.busy_res = 1'b0;
            if (r.command_start) begin
               o.busy_res  = 1'b1;
               cur_op      = r.op;
               cur_address = r.word_address;
               bytes_to_go = r.op[1] ? r.byte_count : 8'd1;
               hdr         = HDR_CTRL;
               tick_count  = cfg.gap_ticks;
               phase       = PH_GAP;
            end
         end
         PH_GAP: begin
            if (tick_count == 16'd0) begin
               phase     = PH_START;
               bit_count = 4'd0;
            end else begin
               tick_count = tick_count - 16'd1;
            end
         end
         PH_START: begin
            if (bit_count == 4'd0) begin
               bit_count = 4'd1;
            end else if (bit_count == 4'd1) begin
               o.sda_level = 1'b0;
               bit_count   = 4'd2;
            end else begin
               o.scl_level = 1'b0;
               o.sda_level = 1'b0;
               if (hdr == HDR_CTRL) begin
                  shifter = {cfg.device_select, 1'b0};
               end else begin
                  shifter = {cfg.device_select, 1'b1};
                  hdr     = HDR_RCTRL;
               end
               bit_count = 4'd0;
               phase     = PH_WBITS;
            end
         end
         PH_WBITS: begin
            o.sda_level = shifter[7];
            o.scl_level = bit_count[0];
            if (bit_count >= BIT_LAST) begin
               phase = PH_WTAIL;
            end else begin
               if (bit_count[0]) shifter = shifter << 1;
               bit_count = bit_count + 4'd1;
            end
         end
         PH_WTAIL: begin
            o.scl_level = 1'b0;
            o.sda_level = shifter[7];
            phase       = PH_ACK_LOW;
         end
         PH_ACK_LOW: begin
            o.scl_level = 1'b0;
            tick_count  = 16'd0;
            phase       = PH_ACK_POLL;
         end
         PH_ACK_POLL: begin
            if (!r.sda_sample) begin
               phase = PH_ACK_END;
            end else if (tick_count >= cfg.ack_wait_limit) begin
               o.ack_missing = 1'b1;
               phase         = PH_ACK_END;
            end else begin
               tick_count = tick_count + 16'd1;
            end
         end
         PH_ACK_END: begin
            o.scl_level = 1'b0;
            phase       = PH_STOP;
            bit_count   = 4'd0;
            if (hdr == HDR_CTRL) begin
               shifter = cur_address;
               hdr     = HDR_ADDR;
               phase   = PH_WBITS;
            end else if (hdr == HDR_ADDR && cur_op[0]) begin
               hdr   = HDR_RSTART;
               phase = PH_START;
            end else if (hdr == HDR_RCTRL) begin
               if (bytes_to_go != 8'd0) begin
                  shifter = 8'd0;
                  phase   = PH_RBITS;
               end
            end else if (hdr == HDR_ADDR || hdr == HDR_DATA) begin
               if (bytes_to_go != 8'd0) begin
                  shifter      = r.data_byte;
                  o.byte_taken = 1'b1;
                  bytes_to_go  = bytes_to_go - 8'd1;
                  hdr          = HDR_DATA;
                  phase        = PH_WBITS;
               end
            end
         end
         PH_RBITS: begin
            o.scl_level = bit_count[0];
            if (bit_count[0]) shifter = {shifter[6:0], r.sda_sample};
            if (bit_count >= BIT_LAST) begin
               o.read_data  = shifter;
               o.read_valid = 1'b1;
               o.read_last  = (bytes_to_go <= 8'd1);
               if (bytes_to_go != 8'd0) bytes_to_go = bytes_to_go - 8'd1;
               bit_count = 4'd0;
               phase     = PH_MACK;
            end else begin
               bit_count = bit_count + 4'd1;
            end
         end
         PH_MACK: begin
            ack_level = (bytes_to_go == 8'd0);
            if (bit_count == 4'd0) begin
               o.scl_level = 1'b0;
               bit_count   = 4'd1;
            end else if (bit_count == 4'd1) begin
               o.scl_level = 1'b0;
               o.sda_level = ack_level;
               bit_count   = 4'd2;
            end else if (bit_count == 4'd2) begin
               o.sda_level = ack_level;
               bit_count   = 4'd3;
            end else begin
               o.scl_level = 1'b0;
               o.sda_level = ack_level;
               bit_count   = 4'd0;
               phase       = (bytes_to_go != 8'd0) ? PH_RBITS : PH_STOP;
            end
         end
         PH_STOP: begin
            if (bit_count == 4'd0) begin
               o.scl_level = 1'b0;
               bit_count   = 4'd1;
            end else if (bit_count == 4'd1) begin
               o.scl_level = 1'b0;
               o.sda_level = 1'b0;
               bit_count   = 4'd2;
            end else if (bit_count == 4'd2) begin
               o.sda_level = 1'b0;
               bit_count   = 4'd3;
            end else begin
               bit_count = 4'd0;
               phase     = PH_IDLE;
            end
         end
         default: begin
            o.busy_res = 1'b0;
            phase      = PH_IDLE;
            bit_count  = 4'd0;
         end
      endcase
      return o;
   endfunction

   task automatic field_check(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg = '{device_select: DEVICE_SELECT_RESET, ack_wait_limit: ACK_WAIT_LIMIT_RESET,
                 gap_ticks: GAP_TICKS_RESET};
         phase       = PH_IDLE;
         bit_count   = '0;
         shifter     = '0;
         bytes_to_go = '0;
         tick_count  = '0;
         cur_op      = '0;
         cur_address = '0;
         hdr         = HDR_CTRL;
         expected_lines.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEVICE_SELECT:  cfg.device_select  = csr_data[6:0];
               CSR_ACK_WAIT_LIMIT: cfg.ack_wait_limit = csr_data;
               CSR_GAP_TICKS:      cfg.gap_ticks      = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               mismatches++;
               $display("%0t ns: response with no request pending, expected none actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_lines.pop_front();
               field_check("scl_level", want.scl_level, rsp_data.scl_level);
               field_check("sda_level", want.sda_level, rsp_data.sda_level);
               field_check("busy_res", want.busy_res, rsp_data.busy_res);
               field_check("byte_taken", want.byte_taken, rsp_data.byte_taken);
               field_check("read_data", want.read_data, rsp_data.read_data);
               field_check("read_valid", want.read_valid, rsp_data.read_valid);
               field_check("read_last", want.read_last, rsp_data.read_last);
               field_check("ack_missing", want.ack_missing, rsp_data.ack_missing);
            end
         end
         if (req_valid && !req_stall) expected_lines.push_back(next_bus_tick(req_data));
      end
      pending <= expected_lines.size();
      errors  <= mismatches;
   end

endmodule

// ----- test/i2c_eeprom_transaction_master_unit_tb.sv -----
// testbench top for the i2c eeprom transaction master
// drives request ticks, random stalls and register writes, gives the verdict
// depends on i2cm_pkg, i2cm_line_monitor and the block under test
module i2c_eeprom_transaction_master_unit_tb
   import i2cm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      OP_BYTE_WRITE = 2'd0,
      OP_BYTE_READ  = 2'd1,
      OP_PAGE_WRITE = 2'd2,
      OP_SEQ_READ   = 2'd3
   } op_type;

   typedef enum {SDA_RANDOM, SDA_SLOW_ACK, SDA_STUCK_HIGH} sda_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEVICE_SELECT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int           errors;
   int           pending;
   int           sent_count = 0;
   int           rsp_count = 0;
   int           hold_at = -1;
   logic         last_busy = 1'b0;
   bit           idle_on = 1'b1;
   bit           noise_on = 1'b1;
   sda_mode_type sda_mode = SDA_RANDOM;
   int           stall_left = 0;
   int           transactions = 0;
   int           cfg_writes = 0;
   int           reads_seen = 0;
   int           timeouts_seen = 0;

   i2c_eeprom_transaction_master_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   i2cm_line_monitor u_monitor (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && !reset && $urandom_range(0, 11) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_count <= 0;
         last_busy <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_count     <= rsp_count + 1;
         last_busy     <= rsp_data.busy_res;
         reads_seen    <= reads_seen + rsp_data.read_valid;
         timeouts_seen <= timeouts_seen + rsp_data.ack_missing;
      end
   end

   function automatic req_type random_tick();
      req_type t;
      t.command_start = noise_on && ($urandom_range(0, 15) == 0);
      t.op            = 2'($urandom);
      t.word_address  = 8'($urandom);
      t.byte_count    = t.command_start ? 8'($urandom_range(0, 2)) : 8'($urandom);
      t.data_byte     = 8'($urandom);
      case (sda_mode)
         SDA_RANDOM:   t.sda_sample = 1'($urandom);
         SDA_SLOW_ACK: t.sda_sample = ($urandom_range(0, 7) != 0);
         default:      t.sda_sample = 1'b1;
      endcase
      return t;
   endfunction

   task automatic send_tick(input req_type item);
      if (sent_count == hold_at) begin
         // hold off until every outstanding request has its response
         req_valid <= 1'b0;
         do @(posedge clock); while (pending != 0);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_writes++;
   endtask

   task automatic configure(input logic [6:0] dev, input logic [15:0] ack,
                            input logic [15:0] gap, input bit with_unused);
      write_reg(CSR_DEVICE_SELECT, {9'($urandom_range(0, 511)), dev});
      write_reg(CSR_ACK_WAIT_LIMIT, ack);
      write_reg(CSR_GAP_TICKS, gap);
      if (with_unused) write_reg(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic run_transaction(input op_type op, input logic [7:0] addr,
                                  input logic [7:0] cnt);
      req_type t;
      int      mark;
      bit      done;
      mark = sent_count;
      t = random_tick();
      t.command_start = 1'b1;
      t.op            = op;
      t.word_address  = addr;
      t.byte_count    = cnt;
      send_tick(t);
      done = 1'b0;
      while (!done) begin
         while (!(rsp_count > mark && !last_busy)) send_tick(random_tick());
         req_valid <= 1'b0;
         while (rsp_count != sent_count) @(posedge clock);
         // a stray start after the stop opens another transaction
         if (last_busy) mark = rsp_count;
         else done = 1'b1;
      end
      transactions++;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset device select and ack limit, short gap
      noise_on = 1'b0;
      write_reg(CSR_GAP_TICKS, 16'd0);
      csr_valid <= 1'b0;
      run_transaction(OP_BYTE_WRITE, 8'h00, 8'd1);

      configure(7'h7F, 16'd0, 16'd0, 1'b1);
      noise_on = 1'b1;
      hold_at  = sent_count + 30;
      sda_mode = SDA_STUCK_HIGH;
      run_transaction(OP_BYTE_READ, 8'hFF, 8'd0);
      sda_mode = SDA_RANDOM;
      run_transaction(OP_PAGE_WRITE, 8'h12, 8'd0);
      run_transaction(OP_SEQ_READ, 8'h34, 8'd0);

      configure(7'($urandom), 16'd3, 16'd2, 1'b0);
      noise_on = 1'b0;
      run_transaction(OP_SEQ_READ, 8'hFE, 8'd2);
      idle_on <= 1'b0;
      sda_mode = SDA_SLOW_ACK;
      run_transaction(OP_PAGE_WRITE, 8'($urandom), 8'd2);
      sda_mode = SDA_RANDOM;

      while (pending != 0 || rsp_count != sent_count) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("ran %0d transactions in %0d bus ticks with %0d register writes",
               transactions, sent_count, cfg_writes);
      $display("received %0d read bytes and saw %0d acknowledge timeouts",
               reads_seen, timeouts_seen);
      if (errors == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/i2cm_pkg.sv
sv/i2cm_csr.sv
sv/i2cm_engine.sv
sv/i2c_eeprom_transaction_master_unit.sv
test/i2cm_line_monitor.sv
test/i2c_eeprom_transaction_master_unit_tb.sv
